@@ sv/stb_pkg.sv @@
// shared types and constants of the timer bank
package stb_pkg;

   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_CREATE = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_START  = 3'd3;
   localparam logic [2:0] CMD_STOP   = 3'd4;
   localparam logic [2:0] CMD_PERIOD = 3'd5;
   localparam logic [2:0] CMD_QUERY  = 3'd6;

   localparam int unsigned EVENT_CAP = 64;
   localparam int unsigned SLOT_W    = 5;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_FIRED  = 1'b1;

   // command from controller to datapath
   typedef struct packed {
      logic load_req;    // capture request fields
      logic exec_cmd;    // apply a non-tick command to the slot store
      logic tick_inc;    // advance the tick counter
      logic sweep_clear; // reset the sweep index and fired flag
      logic sweep_step;  // examine the slot at the sweep index
      logic emit_status; // load a status result into the output register
      logic emit_idle;   // load the no-firing tick result
   } stb_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic is_tick;
      logic sweep_end;   // current slot is the last of a sweep
      logic fires;       // current slot fires
      logic any_fired;   // something fired in this sweep
      logic cap_hit;     // event count reached the cap
      logic none_fired;  // no event at all this step
   } stb_sts_type;

endpackage

@@ sv/stb_datapath.sv @@
// slot store, tick counter, sweep index and result builder of the timer bank
module stb_datapath #(
   parameter int unsigned NUM_TIMERS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  stb_pkg::stb_cmd_type cmd,
   output stb_pkg::stb_sts_type sts,
   input  logic [2:0]          req_command,
   input  logic [4:0]          req_timer_index,
   input  logic [31:0]         req_period,
   input  logic                req_reload_mode,
   output logic                res_load,
   output logic [39:0]         res_data,
   output logic                res_last
);
   import stb_pkg::*;

   localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

   logic [31:0] period_ff [NUM_TIMERS];
   logic [31:0] due_ff    [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] reload_ff, active_ff, used_ff;
   logic [NUM_TIMERS-1:0] active_in, used_in;

   logic [31:0] tick_ff;
   logic [2:0]  cmd_ff;
   logic [4:0]  idx_ff;
   logic [31:0] per_ff;
   logic        rl_ff;
   logic [IW-1:0] sw_ff;
   logic        fired_ff;
   logic [6:0]  nev_ff;
   logic        st_ff;

   logic          valid;
   logic [IW-1:0] ci;
   logic          used;
   logic          st;
   logic          st_ok;
   logic [31:0]   diff;
   logic          fires;
   logic [31:0]   step;
   logic          act_after;

   // request capture, command status taken from the flags before the update
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cmd_ff <= req_command;
         idx_ff <= req_timer_index;
         per_ff <= req_period;
         rl_ff  <= req_reload_mode;
      end
      if (cmd.exec_cmd) st_ff <= !st_ok;
   end

   assign valid = ({27'd0, idx_ff} < NUM_TIMERS);
   assign ci    = idx_ff[IW-1:0];
   assign used  = valid && used_ff[ci];

   // firing test of the swept slot
   assign diff  = tick_ff - due_ff[sw_ff];
   assign fires = used_ff[sw_ff] && active_ff[sw_ff] && !diff[31];
   assign step  = (period_ff[sw_ff] == 32'd0) ? 32'd1 : period_ff[sw_ff];

   // flag updates
   always_comb begin
      active_in = active_ff;
      used_in   = used_ff;
      if (cmd.exec_cmd && valid) begin
         case (cmd_ff)
            CMD_CREATE: begin
               active_in[ci] = 1'b0;
               used_in[ci]   = 1'b1;
            end
            CMD_DELETE: if (used) begin
               active_in[ci] = 1'b0;
               used_in[ci]   = 1'b0;
            end
            CMD_START, CMD_PERIOD: if (used) active_in[ci] = 1'b1;
            CMD_STOP: if (used) active_in[ci] = 1'b0;
            default: ;
         endcase
      end
      if (cmd.sweep_step && fires && !reload_ff[sw_ff]) active_in[sw_ff] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         used_ff   <= '0;
         reload_ff <= '0;
         tick_ff   <= '0;
         fired_ff  <= 1'b0;
         nev_ff    <= '0;
         sw_ff     <= '0;
      end else begin
         active_ff <= active_in;
         used_ff   <= used_in;
         if (cmd.exec_cmd && valid && cmd_ff == CMD_CREATE) reload_ff[ci] <= rl_ff;
         // event count of the step
         if (cmd.tick_inc) begin
            tick_ff <= tick_ff + 32'd1;
            nev_ff  <= '0;
         end else if (cmd.sweep_step && fires) begin
            nev_ff  <= nev_ff + 7'd1;
         end
         if (cmd.sweep_clear) begin
            sw_ff    <= '0;
            fired_ff <= 1'b0;
         end else if (cmd.sweep_step) begin
            sw_ff <= sts.sweep_end ? '0 : sw_ff + IW'(1);
            if (fires) fired_ff <= 1'b1;
         end
      end
   end

   // period and due stores
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) begin
            period_ff[i] <= '0;
            due_ff[i]    <= '0;
         end
      end else if (cmd.exec_cmd && valid) begin
         case (cmd_ff)
            CMD_CREATE: begin
               period_ff[ci] <= per_ff;
               due_ff[ci]    <= '0;
            end
            CMD_START: if (used) due_ff[ci] <= tick_ff + period_ff[ci];
            CMD_PERIOD: if (used) begin
               period_ff[ci] <= per_ff;
               due_ff[ci]    <= tick_ff + per_ff;
            end
            default: ;
         endcase
      end else if (cmd.sweep_step && fires && reload_ff[sw_ff]) begin
         due_ff[sw_ff] <= due_ff[sw_ff] + step;
      end
   end

   // status to the controller
   assign sts.is_tick    = (cmd_ff == CMD_TICK);
   assign sts.sweep_end  = ({{(32-IW){1'b0}}, sw_ff} == NUM_TIMERS - 1);
   assign sts.fires      = fires;
   assign sts.any_fired  = fired_ff || fires;
   assign sts.cap_hit    = (nev_ff == 7'(EVENT_CAP));
   assign sts.none_fired = (nev_ff == 7'd0);

   // result assembly, the is_active field of status results uses flags already updated
   always_comb begin
      case (cmd_ff)
         CMD_CREATE: st_ok = valid;
         CMD_DELETE, CMD_START, CMD_STOP, CMD_PERIOD: st_ok = used;
         CMD_QUERY: st_ok = used && active_ff[ci];
         default: st_ok = 1'b0;
      endcase
   end
   assign st = st_ff;
   assign act_after = fires && reload_ff[sw_ff];

   always_comb begin
      res_load = 1'b0;
      res_last = 1'b0;
      res_data = '0;
      if (cmd.emit_status) begin
         res_load = 1'b1;
         res_last = 1'b1;
         res_data = {tick_ff, valid && used_ff[ci] && active_ff[ci], st, idx_ff, KIND_STATUS};
      end else if (cmd.emit_idle) begin
         res_load = 1'b1;
         res_last = 1'b1;
         res_data = {tick_ff, 1'b0, 1'b0, 5'd0, KIND_STATUS};
      end else if (cmd.sweep_step && fires) begin
         res_load = 1'b1;
         res_last = (nev_ff == 7'(EVENT_CAP - 1)) ||
                    (sts.sweep_end && !fired_ff && 1'b0);
         res_data = {tick_ff, act_after, 1'b0, 5'(sw_ff), KIND_FIRED};
      end
   end

endmodule

@@ sv/stb_control.sv @@
// sequencer of the timer bank: command execution and tick sweeps
module stb_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                out_free,
   input  stb_pkg::stb_sts_type sts,
   output stb_pkg::stb_cmd_type cmd
);
   import stb_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_STAT  = 3'd2;
   localparam logic [2:0] S_SWEEP = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_IDLEV = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            cmd.load_req = 1'b1;
            state_in     = S_EXEC;
         end
         S_EXEC: begin
            if (sts.is_tick) begin
               cmd.tick_inc    = 1'b1;
               cmd.sweep_clear = 1'b1;
               state_in        = S_SWEEP;
            end else begin
               cmd.exec_cmd = 1'b1;
               state_in     = S_STAT;
            end
         end
         S_STAT: if (out_free) begin
            cmd.emit_status = 1'b1;
            state_in        = S_IDLE;
         end
         // one slot per cycle; a firing slot waits for the output register
         S_SWEEP: begin
            if (sts.cap_hit) begin
               state_in = S_CHECK;
            end else if (!sts.fires || out_free) begin
               cmd.sweep_step = 1'b1;
               if (sts.sweep_end) begin
                  state_in = sts.any_fired ? S_SWEEP : S_CHECK;
                  if (sts.any_fired) cmd.sweep_clear = 1'b1;
               end
            end
         end
         S_CHECK: state_in = sts.none_fired ? S_IDLEV : S_IDLE;
         S_IDLEV: if (out_free) begin
            cmd.emit_idle = 1'b1;
            state_in      = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

@@ sv/software_timer_bank_unit.sv @@
// top level of the timer bank: controller, datapath and output register
//
// Requests arrive on req_ (one command per transfer) and results leave on
// rsp_. A non-tick command gives one status result, valid on rsp_ after the
// EXEC and STAT states; the next request is taken once back in idle.
// A tick increments the tick counter, then sweeps the slots one per cycle
// unless a firing slot waits for the output register, repeating the sweep
// while anything fired; each firing gives one result and the final result
// of a step carries rsp_tlast. A tick where nothing fires gives a single
// result after one sweep. A tick with firings runs at least two sweeps;
// the event cap can end it early. One request is in work at a time.
// While the receiver stalls with the output register full, the sweep
// halts at the next firing slot and status results wait.
// Reset clears the tick counter and all slots to free and inactive, and
// empties the hold and output registers.
// Since the last result of a tick is only known at the end, firing results
// are held one deep and the tlast of the held result is set when the step
// ends; no request is taken while a result is held.
module software_timer_bank_unit #(
   parameter int unsigned NUM_TIMERS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[2:0], timer_index[7:3], period[39:8], reload mode[40], zeros
   input  logic [47:0] req_tdata,
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   // event_kind[0], slot_number[5:1], status[6], is_active[7], tick_now[39:8]
   output logic [39:0] rsp_tdata,
   output logic        rsp_tlast
);
   import stb_pkg::*;

   stb_cmd_type cmd;
   stb_sts_type sts;
   logic        res_load, res_last;
   logic [39:0] res_data;

   // hold stage: a firing result waits here until the next one or step end
   logic        hold_ff;
   logic [39:0] hold_data_ff;
   logic        ov_ff;
   logic [39:0] ov_data_ff;
   logic        ov_last_ff;
   logic        out_free;
   logic        flush;
   logic        ctrl_idle;

   stb_control u_ctrl (
      .clock, .reset, .req_tvalid(req_tvalid && !hold_ff), .req_tready(ctrl_idle),
      .out_free, .sts, .cmd
   );

   stb_datapath #(.NUM_TIMERS(NUM_TIMERS)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_command(req_tdata[2:0]), .req_timer_index(req_tdata[7:3]),
      .req_period(req_tdata[39:8]), .req_reload_mode(req_tdata[40]),
      .res_load, .res_data, .res_last
   );

   // input taken only when idle with nothing held
   assign req_tready = ctrl_idle && !hold_ff;
   // output register is free when empty or draining this cycle
   assign out_free = !ov_ff || rsp_tready;
   // step has ended: the held result moves out as the last one
   assign flush = hold_ff && ctrl_idle && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         ov_ff   <= 1'b0;
      end else begin
         if (res_load && (res_data[0] == KIND_STATUS)) begin
            ov_ff      <= 1'b1;
            ov_data_ff <= res_data;
            ov_last_ff <= res_last;
         end else if (res_load) begin
            if (hold_ff) begin
               ov_ff      <= 1'b1;
               ov_data_ff <= hold_data_ff;
               ov_last_ff <= 1'b0;
            end else if (rsp_tready) begin
               ov_ff      <= 1'b0;
            end
            hold_ff      <= 1'b1;
            hold_data_ff <= res_data;
         end else if (flush) begin
            ov_ff      <= 1'b1;
            ov_data_ff <= hold_data_ff;
            ov_last_ff <= 1'b1;
            hold_ff    <= 1'b0;
         end else if (rsp_tready) begin
            ov_ff      <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = ov_data_ff;
   assign rsp_tlast  = ov_last_ff;

endmodule
